@@ sv/brlm_pkg.sv @@
// ----------------------------------------------------------------------------
// brlm_pkg
// Shared types and constants of the bucketed RMS level meter.
// ----------------------------------------------------------------------------
package brlm_pkg;
	localparam int BUCKETS      = 64;
	localparam int BUCKET_W     = $clog2(BUCKETS);
	localparam int MAX_FRAMES   = 4096;
	localparam int MAX_CHANNELS = 8;
	localparam int SUM_W        = 48;
	localparam int FRAME_W      = 13;
	localparam int CHAN_W       = 4;
	localparam int POS_W        = 3;
	localparam int LEVEL_W      = 16;
	localparam int N_W          = FRAME_W + CHAN_W;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam logic [16:0] FULL_SCALE = 17'd32768;

	localparam logic       CMD_CAPTURE = 1'b0;
	localparam logic       CMD_READ    = 1'b1;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_CAP   = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;

	// job from front to back
	typedef enum logic [1:0] {
		JOB_CLEAR,
		JOB_CLOSE,
		JOB_SWAP,
		JOB_READ
	} job_kind_t;

	typedef struct packed {
		job_kind_t            kind;
		logic [SUM_W-1:0]     sum;
		logic [N_W-1:0]       n;
		logic [BUCKET_W-1:0]  bucket;
		logic [11:0]          idx;
		logic [FRAME_W-1:0]   cnt;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CLEAR,
		BK_DIV,
		BK_SQRT,
		BK_RDIV,
		BK_RD,
		BK_OUT
	} bk_state_t;
endpackage

@@ sv/brlm_if.sv @@
// ----------------------------------------------------------------------------
// brlm_in_if / brlm_out_if
// Valid/ready channels of the level meter.
// ----------------------------------------------------------------------------
interface brlm_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] sample;
	logic [12:0]        frame_count;
	logic [11:0]        point_index;
	logic [12:0]        point_count;
	modport source (output valid, command, sample, frame_count, point_index,
		point_count, input ready);
	modport sink (input valid, command, sample, frame_count, point_index,
		point_count, output ready);
endinterface

interface brlm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] level;
	logic [1:0]  status;
	modport source (output valid, level, status, input ready);
	modport sink (input valid, level, status, output ready);
endinterface

@@ sv/bucketed_rms_level_meter.sv @@
// ----------------------------------------------------------------------------
// bucketed_rms_level_meter
// Per-bucket RMS meter over a capture, double banked levels, point reads.
// ----------------------------------------------------------------------------
// Capture samples are accumulated in the front; a bucket close holds the back
// through pop, divide, square root and write, a read through pop, index
// divide, bank read and output.
// Sustained rate is set by the back end: one close or read at a time.
// Async active-low reset clears counters, bank select and valid bits.
module bucketed_rms_level_meter
	import brlm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	brlm_in_if.sink    in_ch,
	brlm_out_if.source out_ch
);
	logic [3:0] chan_q;
	logic       push, pop, full, empty;
	job_t       job, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chan_q <= 4'd2;
		else if (cfg_we) chan_q <= cfg_wdata;
	end

	brlm_front u_front (.clk, .arst_n, .channel_count(chan_q), .in_ch, .q_full(full),
		.job_push(push), .job);
	brlm_queue u_queue (.clk, .arst_n, .push, .din(job), .pop, .head, .full, .empty);
	brlm_back u_back (.clk, .arst_n, .q_empty(empty), .q_head(head), .q_pop(pop),
		.out_ch);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !in_ch.ready) else $error("accept while queue full");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop on empty queue");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid)
		else $error("result dropped");
endmodule

@@ sv/brlm_front.sv @@
// ----------------------------------------------------------------------------
// brlm_front
// Accepts items, keeps capture counters and square sums, emits jobs.
// ----------------------------------------------------------------------------
module brlm_front
	import brlm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [3:0]    channel_count,
	brlm_in_if.sink       in_ch,
	input  logic          q_full,
	output logic          job_push,
	output job_t          job
);
	logic [SUM_W-1:0]    sum_q;
	logic [BUCKET_W:0]   bucket_q;
	logic [FRAME_W-1:0]  fib_q, seen_q, held_q;
	logic [POS_W-1:0]    pos_q;
	logic                pend_q;   // follow-up job (close or swap) pending
	logic                pend_last_q;
	job_t                pend_job_q;

	logic [CHAN_W-1:0]   chans;
	logic                start;
	logic [FRAME_W-1:0]  fc, held_n, fpb, seen_n, fib_n;
	logic [SUM_W-1:0]    sq, sum_n;
	logic                frame_end, last, close;
	logic                acc;
	job_t                pend_job;

	always_comb begin
		chans = channel_count;
		if (chans == '0) chans = 4'd1;
		if (chans > CHAN_W'(MAX_CHANNELS)) chans = CHAN_W'(MAX_CHANNELS);
	end

	assign in_ch.ready = !q_full && !pend_q;
	assign acc = in_ch.valid && in_ch.ready;

	always_comb begin
		start = (seen_q == '0) && (pos_q == '0);
		fc = in_ch.frame_count;
		if (fc > FRAME_W'(MAX_FRAMES)) fc = FRAME_W'(MAX_FRAMES);
		held_n = start ? fc : held_q;
		sq = SUM_W'(unsigned'(32'(in_ch.sample * in_ch.sample)));
		sum_n = (start ? '0 : sum_q) + sq;
		fib_n = (start ? '0 : fib_q) + 1'b1;
		seen_n = seen_q + 1'b1;
		frame_end = ({1'b0, pos_q} + 4'd1) >= chans;
		fpb = held_n >> BUCKET_W;
		if (fpb == '0) fpb = FRAME_W'(1);
		last = frame_end && (seen_n >= held_n);
		close = frame_end && !last && ((start ? '0 : bucket_q) < (BUCKET_W+1)'(BUCKETS-1))
			&& (fib_n >= fpb);
	end

	always_comb begin
		job_push = 1'b0;
		job = '0;
		job.kind = JOB_READ;
		job.idx = in_ch.point_index;
		job.cnt = in_ch.point_count;
		job.sum = sum_n;
		job.n = N_W'(fib_n) * N_W'(chans);
		job.bucket = start ? '0 : bucket_q[BUCKET_W-1:0];
		if (pend_q) begin
			job_push = !q_full;
			job = pend_job_q;
		end else if (acc) begin
			if (in_ch.command == CMD_READ) begin
				job_push = 1'b1;
			end else if (start && in_ch.frame_count == '0) begin
				job_push = 1'b0;
			end else if (start) begin
				job_push = 1'b1;
				job.kind = JOB_CLEAR;
			end else if (last || close) begin
				job_push = 1'b1;
				job.kind = JOB_CLOSE;
			end
		end
	end

	// start sample that also closes: close follows the clear; capture end: swap
	always_comb begin
		pend_job = job;
		pend_job.kind = start ? JOB_CLOSE : JOB_SWAP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0; bucket_q <= '0; fib_q <= '0; seen_q <= '0;
			held_q <= '0; pos_q <= '0; pend_q <= 1'b0; pend_last_q <= 1'b0;
			pend_job_q <= '0;
		end else if (pend_q) begin
			if (!q_full) begin
				if (pend_job_q.kind == JOB_CLOSE && pend_last_q) begin
					pend_job_q.kind <= JOB_SWAP;
				end else begin
					pend_q <= 1'b0;
				end
			end
		end else if (acc && in_ch.command == CMD_CAPTURE
				&& !(start && in_ch.frame_count == '0)) begin
			held_q <= held_n;
			if (!frame_end) begin
				pos_q <= pos_q + 1'b1;
				sum_q <= sum_n;
				fib_q <= start ? '0 : fib_q;
				bucket_q <= start ? '0 : bucket_q;
				seen_q <= seen_q;
			end else begin
				pos_q <= '0;
				if (last) begin
					seen_q <= '0; bucket_q <= '0; fib_q <= '0; sum_q <= '0;
				end else if (close) begin
					seen_q <= seen_n; fib_q <= '0; sum_q <= '0;
					bucket_q <= (start ? '0 : bucket_q) + 1'b1;
				end else begin
					seen_q <= seen_n; fib_q <= fib_n; sum_q <= sum_n;
					bucket_q <= start ? '0 : bucket_q;
				end
			end
			if ((start && close) || last) begin
				pend_q <= 1'b1;
				pend_job_q <= pend_job;
				pend_last_q <= last;
			end
		end
	end
endmodule

@@ sv/brlm_back.sv @@
// ----------------------------------------------------------------------------
// brlm_back
// Runs jobs: bank clear, divide and square root per bucket, bank swap, reads.
// ----------------------------------------------------------------------------
module brlm_back
	import brlm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  job_t     q_head,
	output logic     q_pop,
	brlm_out_if.source out_ch
);
	localparam int BANK_W = BUCKET_W + 1;

	bk_state_t           st_q, st_n;
	logic [LEVEL_W-1:0]  mem [2*BUCKETS];
	logic [BUCKETS-1:0]  vld_q [2];
	logic                vis_q;
	logic                capv_q;
	job_t                job_q;
	logic [SUM_W-1:0]    rem_q, quo_q;
	logic [5:0]          cnt_q;
	logic [SUM_W-1:0]    sv_q, sres_q, sbit_q;
	logic [BUCKET_W+12:0] rnum_q;
	logic [BUCKET_W+12:0] rquo_q;
	logic [LEVEL_W-1:0]  rd_q;
	logic                rdv_q;
	logic [15:0]         lvl_q;
	logic [1:0]          sta_q;
	logic                ov_q;

	logic [SUM_W:0]      dtry;
	logic [SUM_W-1:0]    rnew;
	logic [SUM_W:0]      stry;
	logic [BUCKET_W+13:0] rtry;
	logic [BANK_W-1:0]   waddr, raddr;
	logic [16:0]         lvl_sat;
	logic [BUCKET_W-1:0] rb;

	assign out_ch.valid = ov_q;
	assign out_ch.level = lvl_q;
	assign out_ch.status = sta_q;

	always_comb begin
		rnew = {rem_q[SUM_W-2:0], quo_q[SUM_W-1]};
		dtry = {1'b0, rnew} - {1'b0, {(SUM_W-N_W){1'b0}}, job_q.n};
		stry = {1'b0, sv_q} - {1'b0, sres_q + sbit_q};
		rtry = {rnum_q[BUCKET_W+12:0], 1'b0} - {{(BUCKET_W+1){1'b0}}, job_q.cnt};
		lvl_sat = (sres_q > SUM_W'(FULL_SCALE)) ? FULL_SCALE : sres_q[16:0];
		waddr = {~vis_q, job_q.bucket};
		rb = (rquo_q > (BUCKET_W+13)'(BUCKETS-1)) ? BUCKET_W'(BUCKETS-1)
			: rquo_q[BUCKET_W-1:0];
		raddr = {vis_q, rb};
	end

	always_comb begin
		st_n = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			BK_IDLE: if (!q_empty) begin
				q_pop = 1'b1;
				unique case (q_head.kind)
					JOB_CLEAR: st_n = BK_CLEAR;
					JOB_CLOSE: st_n = BK_DIV;
					JOB_SWAP:  st_n = BK_IDLE;
					JOB_READ:  st_n = BK_RDIV;
					default:   st_n = BK_IDLE;
				endcase
			end
			BK_CLEAR: st_n = BK_IDLE;
			BK_DIV:   if (cnt_q == 6'(SUM_W-1)) st_n = BK_SQRT;
			BK_SQRT:  if (sbit_q == '0) st_n = BK_IDLE;
			BK_RDIV:  if (cnt_q == 6'(BUCKET_W-1)) st_n = BK_RD;
			BK_RD:    st_n = BK_OUT;
			BK_OUT:   if (!ov_q || out_ch.ready) st_n = BK_IDLE;
			default:  st_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_SQRT && sbit_q == '0)
			mem[waddr] <= lvl_sat[15:0];
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE; vis_q <= 1'b0; vld_q[0] <= '0; vld_q[1] <= '0;
			ov_q <= 1'b0; lvl_q <= '0; sta_q <= '0; job_q <= '0; capv_q <= 1'b0;
			rem_q <= '0; quo_q <= '0; cnt_q <= '0; sv_q <= '0; sres_q <= '0;
			sbit_q <= '0; rnum_q <= '0; rquo_q <= '0; rdv_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (st_q == BK_OUT && (!ov_q || out_ch.ready)) ov_q <= 1'b1;
			else if (ov_q && out_ch.ready) ov_q <= 1'b0;
			unique case (st_q)
				BK_IDLE: if (!q_empty) begin
					job_q <= q_head;
					cnt_q <= '0;
					rem_q <= '0;
					quo_q <= q_head.sum;
					rnum_q <= {{(BUCKET_W+1){1'b0}}, q_head.idx};
					rquo_q <= '0;
					if (q_head.kind == JOB_SWAP) begin
						vis_q <= ~vis_q;
						capv_q <= 1'b1;
					end
				end
				BK_CLEAR: vld_q[~vis_q] <= '0;
				BK_DIV: begin
					if (job_q.n == '0) begin
						rem_q <= rnew;
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end else if (!dtry[SUM_W]) begin
						rem_q <= dtry[SUM_W-1:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rnew;
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(SUM_W-1)) begin
						sv_q <= (job_q.n == '0) ? '0 :
							(!dtry[SUM_W] ? {quo_q[SUM_W-2:0], 1'b1}
							: {quo_q[SUM_W-2:0], 1'b0});
						sres_q <= '0;
						sbit_q <= SUM_W'(1) << (SUM_W-2);
					end
				end
				BK_SQRT: begin
					if (sbit_q != '0) begin
						if (!stry[SUM_W]) begin
							sv_q <= stry[SUM_W-1:0];
							sres_q <= (sres_q >> 1) + sbit_q;
						end else begin
							sres_q <= sres_q >> 1;
						end
						sbit_q <= sbit_q >> 2;
					end else begin
						vld_q[~vis_q][job_q.bucket] <= 1'b1;
					end
				end
				BK_RDIV: begin
					if (!rtry[BUCKET_W+13]) begin
						rnum_q <= rtry[BUCKET_W+12:0];
						rquo_q <= {rquo_q[BUCKET_W+11:0], 1'b1};
					end else begin
						rnum_q <= {rnum_q[BUCKET_W+11:0], 1'b0};
						rquo_q <= {rquo_q[BUCKET_W+11:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
				BK_RD: rdv_q <= vld_q[vis_q][rb];
				BK_OUT: if (!ov_q || out_ch.ready) begin
					if (job_q.cnt == '0 || {1'b0, job_q.idx} >= job_q.cnt) begin
						sta_q <= ST_INVALID; lvl_q <= '0;
					end else if (!capv_q) begin
						sta_q <= ST_NO_CAP; lvl_q <= '0;
					end else begin
						sta_q <= ST_OK; lvl_q <= rdv_q ? rd_q : '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ sv/brlm_queue.sv @@
// ----------------------------------------------------------------------------
// brlm_queue
// Short job FIFO between front and back.
// ----------------------------------------------------------------------------
module brlm_queue
	import brlm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);
	job_t             buf_q [QDEPTH];
	logic [QPTR_W:0]  wp_q, rp_q;

	assign empty = wp_q == rp_q;
	assign full = (wp_q[QPTR_W-1:0] == rp_q[QPTR_W-1:0]) && (wp_q[QPTR_W] != rp_q[QPTR_W]);
	assign head = buf_q[rp_q[QPTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) buf_q[wp_q[QPTR_W-1:0]] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (pop && !empty) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

@@ tb/bucketed_rms_level_meter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bucketed_rms_level_meter_tb
// Drives captures and point reads through the valid/ready channels, models
// the bucket sums, the double bank and the read mapping, and checks every
// result level and status in order, against the model or a typed row value.
// ----------------------------------------------------------------------------
module bucketed_rms_level_meter_tb;
	import brlm_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int HOLD_CYCLES    = 400;

	typedef struct {
		logic               command;
		logic signed [15:0] sample;
		logic [12:0]        frame_count;
		logic [11:0]        point_index;
		logic [12:0]        point_count;
		bit                 typed;
		logic [15:0]        level;
		logic [1:0]         status;
	} stim_row_t;

	typedef struct {
		logic [15:0] level;
		logic [1:0]  status;
	} point_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [3:0] cfg_wdata;

	brlm_in_if  in_if ();
	brlm_out_if out_if ();

	bucketed_rms_level_meter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_if),
		.out_ch   (out_if)
	);

	// meter model state
	logic [3:0]         m_chan_reg;
	logic [15:0]        m_banks [0:2*BUCKETS-1];
	logic               m_vis_bank;
	logic               m_levels_valid;
	logic [SUM_W-1:0]   m_sum;
	int unsigned        m_bucket;
	int unsigned        m_frame_in_bucket;
	int unsigned        m_frames_seen;
	int unsigned        m_chan_pos;
	int unsigned        m_held_frames;

	point_result_t      expected_points [$];
	int                 fails;
	int                 items_sent;
	int                 idle_cycles;
	bit                 idle_on;
	bit                 hold_req;

	// driver side copy of the typed expectation for the item on the bus
	bit                 drv_typed;
	logic [15:0]        drv_level;
	logic [1:0]         drv_status;

	stim_row_t          table_rows [$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned eff_channels(input logic [3:0] c);
		if (c == 0)
			return 1;
		if (c > MAX_CHANNELS)
			return MAX_CHANNELS;
		return c;
	endfunction

	function automatic logic [31:0] root_floor(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res[31:0];
	endfunction

	task automatic close_bucket_model(input int unsigned chans);
		logic [63:0] n;
		logic [31:0] lvl;
		n = m_frame_in_bucket * chans;
		lvl = 0;
		if (n != 0)
			lvl = root_floor({16'd0, m_sum} / n);
		if (lvl > FULL_SCALE)
			lvl = FULL_SCALE;
		if (m_bucket < BUCKETS)
			m_banks[(m_vis_bank ^ 1'b1) * BUCKETS + m_bucket] = lvl[15:0];
		m_bucket++;
		m_sum = 0;
		m_frame_in_bucket = 0;
	endtask

	task automatic meter_model(input logic cmd, input logic signed [15:0] smp,
		input logic [12:0] fc_in, input logic [11:0] idx, input logic [12:0] cnt,
		output bit has_point, output point_result_t pt);
		int unsigned chans;
		int unsigned fc;
		int unsigned fpb;
		longint sq;
		int unsigned b;
		has_point = 0;
		pt.level = 0;
		pt.status = ST_OK;
		if (cmd == CMD_CAPTURE) begin
			chans = eff_channels(m_chan_reg);
			sq = longint'(smp) * longint'(smp);
			if (m_frames_seen == 0 && m_chan_pos == 0) begin
				fc = fc_in;
				if (fc == 0)
					return;
				if (fc > MAX_FRAMES)
					fc = MAX_FRAMES;
				m_held_frames = fc;
				m_bucket = 0;
				m_frame_in_bucket = 0;
				m_sum = 0;
				for (int i = 0; i < BUCKETS; i++)
					m_banks[(m_vis_bank ^ 1'b1) * BUCKETS + i] = 0;
			end
			m_sum = m_sum + sq[SUM_W-1:0];
			if (m_chan_pos + 1 < chans) begin
				m_chan_pos++;
				return;
			end
			m_chan_pos = 0;
			m_frames_seen++;
			m_frame_in_bucket++;
			fpb = m_held_frames / BUCKETS;
			if (fpb < 1)
				fpb = 1;
			if (m_frames_seen >= m_held_frames) begin
				close_bucket_model(chans);
				m_vis_bank = m_vis_bank ^ 1'b1;
				m_levels_valid = 1;
				m_frames_seen = 0;
				m_bucket = 0;
				m_frame_in_bucket = 0;
				m_sum = 0;
			end else if (m_bucket < BUCKETS - 1 && m_frame_in_bucket >= fpb) begin
				close_bucket_model(chans);
			end
		end else begin
			has_point = 1;
			if (cnt == 0 || idx >= cnt) begin
				pt.status = ST_INVALID;
			end else if (!m_levels_valid) begin
				pt.status = ST_NO_CAP;
			end else begin
				b = (idx * BUCKETS) / cnt;
				if (b > BUCKETS - 1)
					b = BUCKETS - 1;
				pt.level = m_banks[m_vis_bank * BUCKETS + b];
				if (pt.level > FULL_SCALE)
					pt.level = FULL_SCALE[15:0];
			end
		end
	endtask

	// input monitor: update model and queue expected points
	always @(posedge clk) begin
		bit has_point;
		point_result_t pt;
		if (in_if.valid && in_if.ready) begin
			meter_model(in_if.command, in_if.sample, in_if.frame_count,
				in_if.point_index, in_if.point_count, has_point, pt);
			if (has_point) begin
				if (drv_typed) begin
					pt.level = drv_level;
					pt.status = drv_status;
				end
				expected_points.push_back(pt);
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		point_result_t pt;
		if (out_if.valid && out_if.ready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected point: level %0d status %0d", $time,
					out_if.level, out_if.status);
				fails++;
			end else begin
				pt = expected_points.pop_front();
				if (out_if.level !== pt.level) begin
					$display("%0t: level mismatch: expected %0d actual %0d", $time,
						pt.level, out_if.level);
					fails++;
				end
				if (out_if.status !== pt.status) begin
					$display("%0t: status mismatch: expected %0d actual %0d", $time,
						pt.status, out_if.status);
					fails++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result sink
	initial begin
		bit hold_done;
		hold_done = 0;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end
			if (idle_on && $urandom_range(0, 3) == 0) begin
				out_if.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_item(input logic cmd, input logic signed [15:0] smp,
		input logic [12:0] fc, input logic [11:0] idx, input logic [12:0] cnt,
		input bit typed, input logic [15:0] lvl, input logic [1:0] st);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_if.valid       <= 1'b1;
		in_if.command     <= cmd;
		in_if.sample      <= smp;
		in_if.frame_count <= fc;
		in_if.point_index <= idx;
		in_if.point_count <= cnt;
		drv_typed         <= typed;
		drv_level         <= lvl;
		drv_status        <= st;
		do
			@(posedge clk);
		while (!(in_if.valid && in_if.ready));
		items_sent++;
	endtask

	task automatic send_read();
		logic [12:0] cnt;
		logic [11:0] idx;
		if ($urandom_range(0, 7) == 0) begin
			cnt = $urandom_range(0, 4095);
			idx = $urandom_range(cnt, 4095);
		end else begin
			cnt = $urandom_range(1, 4096);
			idx = $urandom_range(0, cnt - 1);
		end
		send_item(CMD_READ, 16'sd0, 13'($urandom), idx, cnt, 0, 0, ST_OK);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			default: return 16'($urandom);
		endcase
	endfunction

	// frames of samples; fc only on the first one of a fresh capture
	task automatic capture_frames(input int frames, input int chans,
		input logic [12:0] fc, input bit fresh);
		for (int i = 0; i < frames * chans; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_read();
			send_item(CMD_CAPTURE, rand_sample(),
				(fresh && i == 0) ? fc : 13'($urandom), 0, 0, 0, 0, ST_OK);
		end
	endtask

	task automatic quiesce_and_config(input logic [3:0] value);
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		m_chan_reg = value;
	endtask

	task automatic add_row(input logic cmd, input logic signed [15:0] smp,
		input logic [12:0] fc, input logic [11:0] idx, input logic [12:0] cnt,
		input bit typed, input logic [15:0] lvl, input logic [1:0] st);
		stim_row_t r;
		r.command = cmd; r.sample = smp; r.frame_count = fc;
		r.point_index = idx; r.point_count = cnt;
		r.typed = typed; r.level = lvl; r.status = st;
		table_rows.push_back(r);
	endtask

	initial begin
		logic [3:0] chan_choices [10] = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 15};
		logic [3:0] c1;
		logic [3:0] c2;
		int ec1;
		int ec2;
		int fc;
		int k;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'd0;
		in_if.valid = 1'b0;
		in_if.command = CMD_CAPTURE;
		in_if.sample = 0;
		in_if.frame_count = 0;
		in_if.point_index = 0;
		in_if.point_count = 0;
		drv_typed = 0;
		drv_level = 0;
		drv_status = ST_OK;
		fails = 0;
		items_sent = 0;
		idle_cycles = 0;
		idle_on = 1;
		hold_req = 0;
		m_chan_reg = 4'd2;
		for (int i = 0; i < 2 * BUCKETS; i++)
			m_banks[i] = 0;
		m_vis_bank = 0;
		m_levels_valid = 0;
		m_sum = 0;
		m_bucket = 0;
		m_frame_in_bucket = 0;
		m_frames_seen = 0;
		m_chan_pos = 0;
		m_held_frames = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: invalid reads, reads before capture, full scale capture
		add_row(CMD_READ, 0, 0, 0, 0, 1, 0, ST_INVALID);
		add_row(CMD_READ, 0, 0, 5, 5, 1, 0, ST_INVALID);
		add_row(CMD_READ, 0, 0, 4095, 0, 1, 0, ST_INVALID);
		add_row(CMD_READ, 0, 0, 0, 1, 1, 0, ST_NO_CAP);
		add_row(CMD_READ, 0, 0, 4095, 4096, 1, 0, ST_NO_CAP);
		add_row(CMD_CAPTURE, 16'sd1000, 0, 0, 0, 0, 0, ST_OK);
		add_row(CMD_CAPTURE, -16'sd32768, 1, 0, 0, 0, 0, ST_OK);
		add_row(CMD_CAPTURE, -16'sd32768, 0, 0, 0, 0, 0, ST_OK);
		add_row(CMD_READ, 0, 0, 0, 1, 1, 16'd32768, ST_OK);
		add_row(CMD_READ, 0, 0, 1, 64, 1, 0, ST_OK);
		add_row(CMD_READ, 0, 0, 4095, 4096, 1, 0, ST_OK);
		add_row(CMD_CAPTURE, 16'sd32767, 2, 0, 0, 0, 0, ST_OK);
		add_row(CMD_READ, 0, 0, 0, 1, 1, 16'd32768, ST_OK);
		add_row(CMD_CAPTURE, 16'sd0, 13'h1fff, 0, 0, 0, 0, ST_OK);
		add_row(CMD_CAPTURE, -16'sd1, 0, 0, 0, 0, 0, ST_OK);
		add_row(CMD_CAPTURE, 16'sd32767, 0, 0, 0, 0, 0, ST_OK);
		add_row(CMD_READ, 0, 0, 0, 4096, 0, 0, ST_OK);
		add_row(CMD_READ, 0, 0, 2048, 4096, 0, 0, ST_OK);
		add_row(CMD_READ, 0, 0, 4095, 4096, 1, 0, ST_OK);
		foreach (table_rows[i])
			send_item(table_rows[i].command, table_rows[i].sample,
				table_rows[i].frame_count, table_rows[i].point_index,
				table_rows[i].point_count, table_rows[i].typed,
				table_rows[i].level, table_rows[i].status);

		// back pressure: sink holds off while reads pile up
		hold_req = 1;
		for (int i = 0; i < 20; i++)
			send_read();

		// random captures with interleaved reads
		while (items_sent < 340) begin
			c1 = chan_choices[$urandom_range(0, 9)];
			quiesce_and_config(c1);
			ec1 = eff_channels(c1);
			if ($urandom_range(0, 4) == 0)
				send_item(CMD_CAPTURE, rand_sample(), 0, 0, 0, 0, 0, ST_OK);
			fc = $urandom_range(1, 160 / ec1);
			if (fc >= 2 && $urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, fc - 1);
				capture_frames(k, ec1, fc, 1);
				c2 = chan_choices[$urandom_range(0, 9)];
				quiesce_and_config(c2);
				ec2 = eff_channels(c2);
				capture_frames(fc - k, ec2, fc, 0);
			end else begin
				capture_frames(fc, ec1, fc, 1);
			end
			repeat ($urandom_range(3, 8))
				send_read();
		end

		// last part: no idling, one capture of a full bucket set
		idle_on = 0;
		quiesce_and_config(4'd1);
		capture_frames(BUCKETS, 1, 13'd64, 1);
		repeat (12)
			send_read();

		in_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
